// File: hdl/rbsi_pkg.sv
// shared types, constants and float helpers for the ray box slab intersect block
`default_nettype none

package rbsi_pkg;

  // request and result payloads
  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
    logic [31:0] dir_x;
    logic [31:0] dir_y;
    logic [31:0] dir_z;
    logic [31:0] box_min_x;
    logic [31:0] box_min_y;
    logic [31:0] box_min_z;
    logic [31:0] box_max_x;
    logic [31:0] box_max_y;
    logic [31:0] box_max_z;
  } rbsi_in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] distance;
  } rbsi_out_t;

  // float bit patterns
  localparam logic [31:0] FLT_MAX_POS = 32'h7F7F_FFFF;
  localparam logic [31:0] FLT_MAX_NEG = 32'hFF7F_FFFF;
  localparam logic [31:0] MISS_BITS   = 32'hBF80_0000;
  localparam logic [31:0] QNAN_BITS   = 32'h7FC0_0000;
  localparam logic [30:0] INF_MAG     = 31'h7F80_0000;
  localparam logic [31:0] POS_ZERO    = 32'h0000_0000;

  // pipeline depths
  localparam int SUB_LAT   = 5;
  localparam int DIV_STEPS = 25;
  localparam int DIV_LAT   = DIV_STEPS + 3;
  localparam int POST_LAT  = 5;
  localparam int SB_LAT    = SUB_LAT + DIV_LAT;
  localparam int RBSI_LAT  = SUB_LAT + DIV_LAT + POST_LAT;

  function automatic logic f_is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  // ieee less-than: false on nan, signed zeros equal
  function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
    logic res;
    if (f_is_nan(a) || f_is_nan(b)) begin
      res = 1'b0;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = a[31];
    end else if (!a[31]) begin
      res = a[30:0] < b[30:0];
    end else begin
      res = a[30:0] > b[30:0];
    end
    return res;
  endfunction

  function automatic logic f_gt(input logic [31:0] a, input logic [31:0] b);
    return f_lt(b, a);
  endfunction

  // leading zero count, 32 when all zero
  function automatic logic [5:0] f_lzc32(input logic [31:0] v);
    logic [5:0] n;
    logic       done;
    n    = 6'd32;
    done = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!done && v[i]) begin
        n    = 6'(31 - i);
        done = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: hdl/rbsi_fsub.sv
// pipelined single precision subtractor, diff = a - b, round to nearest even
`default_nettype none

module rbsi_fsub import rbsi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_vld,
  output logic [31:0] diff
);

  typedef struct packed {
    logic        sign;
    logic        zsign;
    logic        sub;
    logic [7:0]  exp;
    logic [26:0] mbig;
    logic [26:0] msml;
    logic        spec;
    logic [31:0] sval;
  } al_t;

  typedef struct packed {
    logic        sign;
    logic        zsign;
    logic [7:0]  exp;
    logic [27:0] sum;
    logic        spec;
    logic [31:0] sval;
  } sm_t;

  typedef struct packed {
    logic        sign;
    logic        zsign;
    logic        zero;
    logic [8:0]  enew;
    logic [5:0]  shamt;
    logic [26:0] mant;
    logic        spec;
    logic [31:0] sval;
  } nm_t;

  al_t s1_r, s1_nxt;
  sm_t s2_r, s2_nxt;
  nm_t s3_r, s3_nxt, s4_r, s4_nxt;
  logic [31:0] diff_r, diff_nxt;
  logic [4:0]  vld_r, vld_nxt;

  logic        sx, sy, a_inf, b_inf, swap, sticky;
  logic [7:0]  ex, ey, eb, es, dexp;
  logic [23:0] mx, my, mb, ms;
  logic [26:0] ext, shifted, mask;
  logic [5:0]  lz;
  logic [7:0]  limit;
  logic [23:0] mant24;
  logic        rnd;
  logic [7:0]  efield;
  logic [30:0] mag;

  // stage 1: unpack, specials, order by magnitude, align smaller operand
  always_comb begin
    sx    = a[31];
    sy    = ~b[31];
    a_inf = (a[30:0] == INF_MAG);
    b_inf = (b[30:0] == INF_MAG);
    ex    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    ey    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    mx    = {a[30:23] != 8'd0, a[22:0]};
    my    = {b[30:23] != 8'd0, b[22:0]};
    swap  = b[30:0] > a[30:0];
    eb    = swap ? ey : ex;
    es    = swap ? ex : ey;
    mb    = swap ? my : mx;
    ms    = swap ? mx : my;
    dexp  = eb - es;
    ext   = {ms, 3'b000};
    if (dexp >= 8'd27) begin
      shifted = 27'd0;
      sticky  = |ms;
    end else begin
      shifted = ext >> dexp[4:0];
      mask    = (27'd1 << dexp[4:0]) - 27'd1;
      sticky  = |(ext & mask);
    end
    if (dexp >= 8'd27) begin
      mask = 27'd0;
    end else begin
      mask = (27'd1 << dexp[4:0]) - 27'd1;
    end
    s1_nxt.sign  = swap ? sy : sx;
    s1_nxt.zsign = sx & sy;
    s1_nxt.sub   = sx ^ sy;
    s1_nxt.exp   = eb;
    s1_nxt.mbig  = {mb, 3'b000};
    s1_nxt.msml  = shifted | {26'd0, sticky};
    s1_nxt.spec  = 1'b1;
    if (f_is_nan(a) || f_is_nan(b)) begin
      s1_nxt.sval = QNAN_BITS;
    end else if (a_inf && b_inf) begin
      s1_nxt.sval = (sx == sy) ? a : QNAN_BITS;
    end else if (a_inf) begin
      s1_nxt.sval = a;
    end else if (b_inf) begin
      s1_nxt.sval = {sy, INF_MAG};
    end else begin
      s1_nxt.sval = POS_ZERO;
      s1_nxt.spec = 1'b0;
    end
  end

  // stage 2: magnitude add or subtract
  always_comb begin
    s2_nxt.sign  = s1_r.sign;
    s2_nxt.zsign = s1_r.zsign;
    s2_nxt.exp   = s1_r.exp;
    s2_nxt.spec  = s1_r.spec;
    s2_nxt.sval  = s1_r.sval;
    if (s1_r.sub) begin
      s2_nxt.sum = {1'b0, s1_r.mbig} - {1'b0, s1_r.msml};
    end else begin
      s2_nxt.sum = {1'b0, s1_r.mbig} + {1'b0, s1_r.msml};
    end
  end

  // stage 3: carry fold or leading zero count, limited by subnormal floor
  always_comb begin
    s3_nxt.sign  = s2_r.sign;
    s3_nxt.zsign = s2_r.zsign;
    s3_nxt.zero  = (s2_r.sum == 28'd0);
    s3_nxt.spec  = s2_r.spec;
    s3_nxt.sval  = s2_r.sval;
    lz    = f_lzc32({s2_r.sum[26:0], 5'b00000});
    limit = s2_r.exp - 8'd1;
    if (s2_r.sum[27]) begin
      s3_nxt.mant  = {s2_r.sum[27:2], s2_r.sum[1] | s2_r.sum[0]};
      s3_nxt.shamt = 6'd0;
      s3_nxt.enew  = {1'b0, s2_r.exp} + 9'd1;
    end else begin
      s3_nxt.mant  = s2_r.sum[26:0];
      s3_nxt.shamt = ({2'b00, lz} <= limit) ? lz : limit[5:0];
      s3_nxt.enew  = {1'b0, s2_r.exp} - {3'b000, s3_nxt.shamt};
    end
  end

  // stage 4: normalizing shift
  always_comb begin
    s4_nxt      = s3_r;
    s4_nxt.mant = s3_r.mant << s3_r.shamt;
  end

  // stage 5: round to nearest even and pack
  always_comb begin
    mant24 = s4_r.mant[26:3];
    rnd    = s4_r.mant[2] & (s4_r.mant[1] | s4_r.mant[0] | mant24[0]);
    efield = mant24[23] ? s4_r.enew[7:0] : 8'd0;
    mag    = {efield, mant24[22:0]} + {30'd0, rnd};
    if (s4_r.spec) begin
      diff_nxt = s4_r.sval;
    end else if (s4_r.zero) begin
      diff_nxt = {s4_r.zsign, 31'd0};
    end else if (s4_r.enew >= 9'd255) begin
      diff_nxt = {s4_r.sign, INF_MAG};
    end else begin
      diff_nxt = {s4_r.sign, mag};
    end
  end

  assign vld_nxt = {vld_r[3:0], in_vld};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 5'd0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    s1_r   <= s1_nxt;
    s2_r   <= s2_nxt;
    s3_r   <= s3_nxt;
    s4_r   <= s4_nxt;
    diff_r <= diff_nxt;
  end

  assign out_vld = vld_r[4];
  assign diff    = diff_r;

endmodule

`default_nettype wire

// File: hdl/rbsi_fdiv.sv
// pipelined single precision divider, one quotient bit per stage, round to nearest even
`default_nettype none

module rbsi_fdiv import rbsi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_vld,
  output logic [31:0] quot
);

  typedef struct packed {
    logic        sign;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [5:0]  lza;
    logic [5:0]  lzb;
    logic        spec;
    logic [31:0] sval;
  } up_t;

  typedef struct packed {
    logic               sign;
    logic signed [9:0]  e;
    logic [23:0]        mb;
    logic [24:0]        rem;
    logic [24:0]        q;
    logic               spec;
    logic [31:0]        sval;
  } it_t;

  up_t s1_r, s1_nxt;
  it_t it_r   [DIV_STEPS+1];
  it_t it_nxt [DIV_STEPS+1];
  logic [DIV_STEPS+2:0] vld_r, vld_nxt;
  logic [31:0] quot_r, quot_nxt;

  logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  logic [23:0]       ma_n, mb_n;
  logic signed [9:0] ea_s, eb_s, e_q;
  logic              lt_m;

  // stage 1: specials and leading zeros of subnormal significands
  always_comb begin
    a_nan  = f_is_nan(a);
    b_nan  = f_is_nan(b);
    a_inf  = (a[30:0] == INF_MAG);
    b_inf  = (b[30:0] == INF_MAG);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    sgn    = a[31] ^ b[31];
    s1_nxt.sign = sgn;
    s1_nxt.ea   = a[30:23];
    s1_nxt.eb   = b[30:23];
    s1_nxt.ma   = {a[30:23] != 8'd0, a[22:0]};
    s1_nxt.mb   = {b[30:23] != 8'd0, b[22:0]};
    s1_nxt.lza  = f_lzc32({s1_nxt.ma, 8'd0});
    s1_nxt.lzb  = f_lzc32({s1_nxt.mb, 8'd0});
    s1_nxt.spec = 1'b1;
    if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
      s1_nxt.sval = QNAN_BITS;
    end else if (a_inf || b_zero) begin
      s1_nxt.sval = {sgn, INF_MAG};
    end else if (a_zero || b_inf) begin
      s1_nxt.sval = {sgn, 31'd0};
    end else begin
      s1_nxt.sval = POS_ZERO;
      s1_nxt.spec = 1'b0;
    end
  end

  // stage 2: normalize, quotient exponent, pre-scale dividend into [mb, 2mb)
  always_comb begin
    ma_n = s1_r.ma << s1_r.lza[4:0];
    mb_n = s1_r.mb << s1_r.lzb[4:0];
    ea_s = ((s1_r.ea == 8'd0) ? 10'sd1 : $signed({2'b00, s1_r.ea}))
           - $signed({4'd0, s1_r.lza});
    eb_s = ((s1_r.eb == 8'd0) ? 10'sd1 : $signed({2'b00, s1_r.eb}))
           - $signed({4'd0, s1_r.lzb});
    lt_m = ma_n < mb_n;
    e_q  = ea_s - eb_s + 10'sd127 - (lt_m ? 10'sd1 : 10'sd0);
    it_nxt[0].sign = s1_r.sign;
    it_nxt[0].e    = e_q;
    it_nxt[0].mb   = mb_n;
    it_nxt[0].rem  = lt_m ? {ma_n, 1'b0} : {1'b0, ma_n};
    it_nxt[0].q    = 25'd0;
    it_nxt[0].spec = s1_r.spec;
    it_nxt[0].sval = s1_r.sval;
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic        ge;
    logic [24:0] rsub;
    always_comb begin
      ge   = it_r[k].rem >= {1'b0, it_r[k].mb};
      rsub = ge ? (it_r[k].rem - {1'b0, it_r[k].mb}) : it_r[k].rem;
      it_nxt[k+1]     = it_r[k];
      it_nxt[k+1].rem = {rsub[23:0], 1'b0};
      it_nxt[k+1].q   = {it_r[k].q[23:0], ge};
    end
  end

  it_t               fin;
  logic              sticky, lost, g, rnd;
  logic [9:0]        shw;
  logic [4:0]        sh;
  logic [56:0]       ext;
  logic [24:0]       qs;
  logic [23:0]       mant24;
  logic [7:0]        efield;
  logic [30:0]       mag;

  // last stage: subnormal right shift, round to nearest even, pack
  always_comb begin
    fin    = it_r[DIV_STEPS];
    sticky = (fin.rem != 25'd0);
    shw    = 10'(10'sd1 - fin.e);
    sh     = (shw > 10'd31) ? 5'd31 : shw[4:0];
    ext    = {fin.q, 32'd0} >> sh;
    if (fin.e >= 10'sd1) begin
      qs     = fin.q;
      lost   = 1'b0;
      efield = fin.e[7:0];
    end else begin
      qs     = ext[56:32];
      lost   = |ext[31:0];
      efield = 8'd0;
    end
    mant24 = qs[24:1];
    g      = qs[0];
    rnd    = g & (sticky | lost | mant24[0]);
    mag    = {efield, mant24[22:0]} + {30'd0, rnd};
    if (fin.spec) begin
      quot_nxt = fin.sval;
    end else if (fin.e >= 10'sd255) begin
      quot_nxt = {fin.sign, INF_MAG};
    end else begin
      quot_nxt = {fin.sign, mag};
    end
  end

  // one valid bit per register stage: setup, steps, rounding
  assign vld_nxt = {vld_r[DIV_STEPS+1:0], in_vld};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    for (int i = 0; i <= DIV_STEPS; i++) begin
      it_r[i] <= it_nxt[i];
    end
    quot_r <= quot_nxt;
  end

  assign out_vld = vld_r[DIV_STEPS+2];
  assign quot    = quot_r;

endmodule

`default_nettype wire

// File: hdl/ray_box_slab_intersect.sv
// top level: ray against axis-aligned box slab test, fully pipelined
//
// a request (ray origin, direction, box corners, all ieee single bit patterns)
// is taken at a rising edge where start is high and busy is low. busy is low
// whenever reset is released, so a new request may come in every cycle.
// each request gives one result: out_strobe is high for one cycle with hit
// and distance on out_res; a miss reports distance -1.0.
// from the accepting edge to the edge that takes the result, a request goes
// through the 25-stage restoring divider (one quotient bit per stage),
// plus 5 stages of subtraction, 3 of divider setup and rounding, and 5 of
// slab ordering, interval narrowing (one axis per stage) and selection.
// throughput is one request per cycle, results in request order.
// the receiver cannot stall; results are never held.
// synchronous reset clears all valid bits, drops requests in flight and
// holds busy high while asserted.
`default_nettype none

module ray_box_slab_intersect import rbsi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  rbsi_in_t  in_req,
  output logic      out_strobe,
  output rbsi_out_t out_res
);

  typedef struct packed {
    logic [2:0] zdir;
    logic       zmiss;
  } sb_t;

  typedef struct packed {
    logic [2:0][31:0] slo;
    logic [2:0][31:0] shi;
    logic [2:0]       zdir;
    logic             zmiss;
    logic [31:0]      near;
    logic [31:0]      far;
  } nw_t;

  logic             accept;
  logic [2:0][31:0] org, dir, blo, bhi;
  logic [2:0]       zmiss_ax;
  sb_t              sb_nxt;
  sb_t              sb_r  [SB_LAT];
  logic [2:0][31:0] dir_r [SUB_LAT];

  logic [2:0][31:0] dlo, dhi, qlo, qhi;
  logic [2:0]       vdlo, vdhi, vqlo, vqhi;

  nw_t        nw_r   [4];
  nw_t        nw_nxt [4];
  logic [3:0] nv_r, nv_nxt;
  rbsi_out_t  res_r, res_nxt;
  logic       strobe_r, strobe_nxt;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  assign org = {in_req.origin_z, in_req.origin_y, in_req.origin_x};
  assign dir = {in_req.dir_z, in_req.dir_y, in_req.dir_x};
  assign blo = {in_req.box_min_z, in_req.box_min_y, in_req.box_min_x};
  assign bhi = {in_req.box_max_z, in_req.box_max_y, in_req.box_max_x};

  // zero-direction axes and their containment test
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sb_nxt.zdir[i] = (dir[i][30:0] == 31'd0);
      zmiss_ax[i]    = sb_nxt.zdir[i] &
                       (f_lt(org[i], blo[i]) | f_gt(org[i], bhi[i]));
    end
    sb_nxt.zmiss = |zmiss_ax;
  end

  // side info and direction delay lines
  always_ff @(posedge clk) begin
    sb_r[0]  <= sb_nxt;
    dir_r[0] <= dir;
    for (int i = 1; i < SB_LAT; i++) begin
      sb_r[i] <= sb_r[i-1];
    end
    for (int i = 1; i < SUB_LAT; i++) begin
      dir_r[i] <= dir_r[i-1];
    end
  end

  // per axis: corner minus origin, then divide by direction
  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    rbsi_fsub u_sub_lo (
      .clk(clk), .rst_n(rst_n), .in_vld(accept), .a(blo[ax]), .b(org[ax]),
      .out_vld(vdlo[ax]), .diff(dlo[ax])
    );
    rbsi_fsub u_sub_hi (
      .clk(clk), .rst_n(rst_n), .in_vld(accept), .a(bhi[ax]), .b(org[ax]),
      .out_vld(vdhi[ax]), .diff(dhi[ax])
    );
    rbsi_fdiv u_div_lo (
      .clk(clk), .rst_n(rst_n), .in_vld(vdlo[ax]), .a(dlo[ax]),
      .b(dir_r[SUB_LAT-1][ax]), .out_vld(vqlo[ax]), .quot(qlo[ax])
    );
    rbsi_fdiv u_div_hi (
      .clk(clk), .rst_n(rst_n), .in_vld(vdhi[ax]), .a(dhi[ax]),
      .b(dir_r[SUB_LAT-1][ax]), .out_vld(vqhi[ax]), .quot(qhi[ax])
    );
  end

  // put slab distances in ascending order
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (f_gt(qlo[i], qhi[i])) begin
        nw_nxt[0].slo[i] = qhi[i];
        nw_nxt[0].shi[i] = qlo[i];
      end else begin
        nw_nxt[0].slo[i] = qlo[i];
        nw_nxt[0].shi[i] = qhi[i];
      end
    end
    nw_nxt[0].zdir  = sb_r[SB_LAT-1].zdir;
    nw_nxt[0].zmiss = sb_r[SB_LAT-1].zmiss;
    nw_nxt[0].near  = FLT_MAX_NEG;
    nw_nxt[0].far   = FLT_MAX_POS;
  end

  // narrow the interval, one axis per stage in x, y, z order
  for (genvar st = 0; st < 3; st++) begin : g_narrow
    always_comb begin
      nw_nxt[st+1] = nw_r[st];
      if (!nw_r[st].zdir[st]) begin
        if (f_gt(nw_r[st].slo[st], nw_r[st].near)) begin
          nw_nxt[st+1].near = nw_r[st].slo[st];
        end
        if (f_lt(nw_r[st].shi[st], nw_r[st].far)) begin
          nw_nxt[st+1].far = nw_r[st].shi[st];
        end
      end
    end
  end

  logic missed;

  // final miss test and distance select
  always_comb begin
    missed = nw_r[3].zmiss | f_gt(nw_r[3].near, nw_r[3].far) |
             f_lt(nw_r[3].far, POS_ZERO);
    if (missed) begin
      res_nxt.hit      = 1'b0;
      res_nxt.distance = MISS_BITS;
    end else begin
      res_nxt.hit      = 1'b1;
      res_nxt.distance = f_gt(nw_r[3].near, POS_ZERO) ? nw_r[3].near : nw_r[3].far;
    end
  end

  assign nv_nxt     = {nv_r[2:0], &{vqlo, vqhi}};
  assign strobe_nxt = nv_r[3];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r     <= 4'd0;
      strobe_r <= 1'b0;
    end else begin
      nv_r     <= nv_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      nw_r[i] <= nw_nxt[i];
    end
    res_r <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

endmodule

`default_nettype wire

// File: hdl/rbsi_chk.sv
// port-level checker for the ray box slab intersect block, with its bind
`default_nettype none

module rbsi_chk import rbsi_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input rbsi_out_t out_res
);

  // every result traces back to a request taken at the pipeline latency
  a_strobe_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, RBSI_LAT))
    else $error("result strobe without a matching request");

  // a miss always reports -1.0
  a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_res.hit) |-> (out_res.distance == MISS_BITS))
    else $error("miss with wrong distance code");

  // a hit distance is never a nan
  a_hit_not_nan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.hit) |-> !f_is_nan(out_res.distance))
    else $error("hit distance is nan");

  // a hit lies ahead: positive or a signed zero
  a_hit_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.hit) |->
      (!out_res.distance[31] || (out_res.distance[30:0] == 31'd0)))
    else $error("hit distance is negative");

endmodule

bind ray_box_slab_intersect rbsi_chk u_rbsi_chk (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_strobe(out_strobe),
  .out_res(out_res)
);

`default_nettype wire

// File: tb/sv/ray_box_slab_intersect_test.sv
// self-checking testbench for the ray box slab intersect block
`default_nettype none

module ray_box_slab_intersect_test;
  import rbsi_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 60;
  localparam int N_RANDOM = 830;

  // float bit patterns used by the stimulus
  localparam logic [31:0] F_ONE = 32'h3F80_0000;
  localparam logic [31:0] F_NEG_ONE = 32'hBF80_0000;
  localparam logic [31:0] F_TWO = 32'h4000_0000;
  localparam logic [31:0] F_FIVE = 32'h40A0_0000;
  localparam logic [31:0] F_NEG_FIVE = 32'hC0A0_0000;
  localparam logic [31:0] F_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] F_INF = 32'h7F80_0000;
  localparam logic [31:0] F_NEG_INF = 32'hFF80_0000;
  localparam logic [31:0] F_TINY = 32'h0000_0001;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  rbsi_in_t in_req;
  logic out_strobe;
  rbsi_out_t out_res;

  rbsi_in_t pending_rays_q[$];
  bit drain_first_q[$];
  rbsi_out_t expected_hits_q[$];
  int gap_left;
  int idle_cycles;
  int mismatches;

  ray_box_slab_intersect u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_strobe(out_strobe),
    .out_res(out_res)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // single precision helpers, round to nearest even, subnormals kept
  function automatic logic fp_is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic fp_less(input logic [31:0] a, input logic [31:0] b);
    if (fp_is_nan(a) || fp_is_nan(b)) return 1'b0;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

  // value is sig * 2^ex, plus a sticky bit below sig
  function automatic logic [31:0] fp_pack(input logic s, input logic [65:0] sig,
                                          input int ex, input logic sticky);
    int p;
    int sh;
    int e;
    logic [65:0] m;
    logic rb;
    logic st;
    if (sig == '0) return {s, 31'd0};
    p = 65;
    while (!sig[p]) p--;
    sh = p - 23;
    e = ex + sh + 150;
    if (e < 1) begin
      sh += 1 - e;
      e = 1;
    end
    if (sh > 66) begin
      m = '0;
      rb = 1'b0;
      st = 1'b1;
    end else if (sh > 0) begin
      m = sig >> sh;
      rb = sig[sh-1];
      st = sticky | ((sig & ((66'd1 << (sh - 1)) - 66'd1)) != '0);
    end else begin
      m = sig << (-sh);
      rb = 1'b0;
      st = sticky;
    end
    if (rb && (st || m[0])) m = m + 66'd1;
    if (m[24]) begin
      m = m >> 1;
      e++;
    end
    if (e >= 255) return {s, 8'hFF, 23'd0};
    return {s, m[23] ? 8'(e) : 8'd0, m[22:0]};
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    int ex;
    int ey;
    int d;
    logic [65:0] big;
    logic [65:0] sml;
    logic [65:0] sig;
    if (fp_is_nan(a) || fp_is_nan(b)) return QNAN_BITS;
    if (a[30:0] == INF_MAG) begin
      if (b[30:0] == INF_MAG && a[31] != b[31]) return QNAN_BITS;
      return a;
    end
    if (b[30:0] == INF_MAG) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 31'd0) return b;
    if (b[30:0] == 31'd0) return a;
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    ex = (x[30:23] == 8'd0) ? 1 : int'(x[30:23]);
    ey = (y[30:23] == 8'd0) ? 1 : int'(y[30:23]);
    d = ex - ey;
    big = 66'({x[30:23] != 8'd0, x[22:0]}) << 40;
    // far below the guard bits only the fact that it is nonzero counts
    if (d > 40) sml = 66'd1;
    else sml = (66'({y[30:23] != 8'd0, y[22:0]}) << 40) >> d;
    sig = (x[31] == y[31]) ? big + sml : big - sml;
    if (sig == '0) return POS_ZERO;
    return fp_pack(x[31], sig, ex - 190, 1'b0);
  endfunction

  function automatic logic [31:0] fp_div(input logic [31:0] a, input logic [31:0] b);
    logic s;
    int ea;
    int eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [65:0] quo;
    logic [65:0] rem;
    s = a[31] ^ b[31];
    if (fp_is_nan(a) || fp_is_nan(b)) return QNAN_BITS;
    if ((a[30:0] == INF_MAG && b[30:0] == INF_MAG) ||
        (a[30:0] == 31'd0 && b[30:0] == 31'd0)) return QNAN_BITS;
    if (a[30:0] == INF_MAG || b[30:0] == 31'd0) return {s, 8'hFF, 23'd0};
    if (a[30:0] == 31'd0 || b[30:0] == INF_MAG) return {s, 31'd0};
    ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    while (!ma[23]) begin
      ma = ma << 1;
      ea--;
    end
    while (!mb[23]) begin
      mb = mb << 1;
      eb--;
    end
    quo = (66'(ma) << 40) / 66'(mb);
    rem = (66'(ma) << 40) % 66'(mb);
    return fp_pack(s, quo, ea - eb - 40, rem != '0);
  endfunction

  // slab test over x, y, z narrowing the interval of ray distances
  function automatic rbsi_out_t slab_hit(input rbsi_in_t r);
    logic [31:0] org[3];
    logic [31:0] dir[3];
    logic [31:0] lo[3];
    logic [31:0] hi[3];
    logic [31:0] near_t;
    logic [31:0] far_t;
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] sw;
    logic missed;
    rbsi_out_t res;
    org = '{r.origin_x, r.origin_y, r.origin_z};
    dir = '{r.dir_x, r.dir_y, r.dir_z};
    lo = '{r.box_min_x, r.box_min_y, r.box_min_z};
    hi = '{r.box_max_x, r.box_max_y, r.box_max_z};
    near_t = FLT_MAX_NEG;
    far_t = FLT_MAX_POS;
    missed = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (!missed) begin
        if (dir[a][30:0] == 31'd0) begin
          if (fp_less(org[a], lo[a]) || fp_less(hi[a], org[a])) missed = 1'b1;
        end else begin
          s0 = fp_div(fp_add(lo[a], {~org[a][31], org[a][30:0]}), dir[a]);
          s1 = fp_div(fp_add(hi[a], {~org[a][31], org[a][30:0]}), dir[a]);
          if (fp_less(s1, s0)) begin
            sw = s0;
            s0 = s1;
            s1 = sw;
          end
          if (fp_less(near_t, s0)) near_t = s0;
          if (fp_less(s1, far_t)) far_t = s1;
        end
      end
    end
    if (fp_less(far_t, near_t) || fp_less(far_t, POS_ZERO)) missed = 1'b1;
    if (missed) begin
      res.hit = 1'b0;
      res.distance = MISS_BITS;
    end else begin
      res.hit = 1'b1;
      res.distance = fp_less(POS_ZERO, near_t) ? near_t : far_t;
    end
    return res;
  endfunction

  // stimulus helpers
  function automatic rbsi_in_t mk_ray(input logic [31:0] ox, oy, oz, dx, dy, dz,
                                      input logic [31:0] lx, ly, lz, hx, hy, hz);
    rbsi_in_t r;
    r = '{ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz};
    return r;
  endfunction

  function automatic logic [31:0] nice_float();
    return {1'($urandom), 8'($urandom_range(118, 132)), 23'($urandom)};
  endfunction

  function automatic logic [31:0] odd_float();
    logic [31:0] v;
    case ($urandom_range(0, 11))
      0: v = POS_ZERO;
      1: v = F_NEG_ZERO;
      2: v = F_INF;
      3: v = F_NEG_INF;
      4: v = {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
      5: v = FLT_MAX_POS;
      6: v = FLT_MAX_NEG;
      7: v = {1'($urandom), 8'd0, 23'($urandom)};
      8: v = F_ONE;
      9: v = F_NEG_ONE;
      10: v = $urandom;
      default: v = nice_float();
    endcase
    return v;
  endfunction

  // a ray aimed at a corner-plane point of a box, so many requests hit
  function automatic rbsi_in_t aimed_ray();
    logic [31:0] lo[3];
    logic [31:0] hi[3];
    logic [31:0] org[3];
    logic [31:0] dir[3];
    logic [31:0] tgt;
    logic [31:0] sw;
    for (int a = 0; a < 3; a++) begin
      lo[a] = nice_float();
      hi[a] = nice_float();
      if (fp_less(hi[a], lo[a]) && $urandom_range(0, 9) != 0) begin
        sw = lo[a];
        lo[a] = hi[a];
        hi[a] = sw;
      end
      org[a] = nice_float();
      tgt = $urandom_range(0, 1) ? lo[a] : hi[a];
      dir[a] = fp_add(tgt, {~org[a][31], org[a][30:0]});
      case ($urandom_range(0, 15))
        0: dir[a] = POS_ZERO;
        1: dir[a] = F_NEG_ZERO;
        2: dir[a] = {~dir[a][31], dir[a][30:0]};
        3: org[a] = lo[a];
        default: ;
      endcase
    end
    return mk_ray(org[0], org[1], org[2], dir[0], dir[1], dir[2],
                  lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  function automatic rbsi_in_t odd_ray();
    logic [31:0] f[12];
    for (int i = 0; i < 12; i++) f[i] = $urandom_range(0, 1) ? odd_float() : nice_float();
    return mk_ray(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], f[10], f[11]);
  endfunction

  task automatic queue_ray(input rbsi_in_t r, input bit drain);
    pending_rays_q.insert(pending_rays_q.size(), r);
    drain_first_q.insert(drain_first_q.size(), drain);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_req <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) expected_hits_q.insert(expected_hits_q.size(), slab_hit(in_req));
      if (start && busy) begin
        // request still waiting, hold it
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_rays_q.size() == 0 ||
                   (drain_first_q[0] && expected_hits_q.size() != 0)) begin
        start <= 1'b0;
      end else if (pending_rays_q.size() > 100 && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 7);
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        in_req <= pending_rays_q.pop_front();
        void'(drain_first_q.pop_front());
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    rbsi_out_t want;
    if (rst_n && out_strobe) begin
      if (expected_hits_q.size() == 0) begin
        report_mismatch("unexpected result", {31'd0, out_res.hit}, 32'd0);
      end else begin
        want = expected_hits_q.pop_front();
        if (out_res.hit !== want.hit)
          report_mismatch("hit", {31'd0, out_res.hit}, {31'd0, want.hit});
        if (out_res.distance !== want.distance)
          report_mismatch("distance", out_res.distance, want.distance);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** ray_box_slab_intersect: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reset, stimulus and end of run
  initial begin
    rst_n = 1'b0;

    // straight hit along z, distance 4
    queue_ray(mk_ray(POS_ZERO, POS_ZERO, F_NEG_FIVE, POS_ZERO, POS_ZERO, F_ONE,
                     F_NEG_ONE, F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE, F_ONE), 1'b0);
    // pointing away from the box
    queue_ray(mk_ray(POS_ZERO, POS_ZERO, F_NEG_FIVE, POS_ZERO, POS_ZERO, F_NEG_ONE,
                     F_NEG_ONE, F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE, F_ONE), 1'b0);
    // origin inside, distance is the exit
    queue_ray(mk_ray(POS_ZERO, POS_ZERO, POS_ZERO, F_ONE, F_TWO, F_NEG_ONE,
                     F_NEG_ONE, F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE, F_ONE), 1'b0);
    // negative zero direction takes the containment test
    queue_ray(mk_ray(F_FIVE, POS_ZERO, F_NEG_FIVE, F_NEG_ZERO, F_NEG_ZERO, F_ONE,
                     F_NEG_ONE, F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE, F_ONE), 1'b0);
    queue_ray(mk_ray(POS_ZERO, POS_ZERO, F_NEG_FIVE, F_NEG_ZERO, F_NEG_ZERO, F_ONE,
                     F_NEG_ONE, F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE, F_ONE), 1'b0);
    // nan origin on a zero direction axis never misses
    queue_ray(mk_ray(QNAN_BITS, POS_ZERO, F_NEG_FIVE, POS_ZERO, POS_ZERO, F_ONE,
                     F_NEG_ONE, F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE, F_ONE), 1'b0);
    // nan direction, nan slab distances never narrow
    queue_ray(mk_ray(POS_ZERO, POS_ZERO, F_NEG_FIVE, QNAN_BITS, 32'hFFFF_FFFF, F_ONE,
                     F_NEG_ONE, F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE, F_ONE), 1'b0);
    // no direction at all, inside and outside
    queue_ray(mk_ray(POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO, F_NEG_ZERO, POS_ZERO,
                     F_NEG_ONE, F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE, F_ONE), 1'b0);
    queue_ray(mk_ray(POS_ZERO, POS_ZERO, F_FIVE, POS_ZERO, POS_ZERO, POS_ZERO,
                     F_NEG_ONE, F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE, F_ONE), 1'b0);
    // inverted box, zero direction then nonzero
    queue_ray(mk_ray(POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO, F_ONE,
                     F_ONE, F_NEG_ONE, F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE), 1'b0);
    queue_ray(mk_ray(POS_ZERO, POS_ZERO, F_NEG_FIVE, POS_ZERO, POS_ZERO, F_ONE,
                     F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE, F_ONE, F_NEG_ONE), 1'b0);
    // entry exactly at zero, origin on the face
    queue_ray(mk_ray(POS_ZERO, POS_ZERO, F_NEG_ONE, POS_ZERO, POS_ZERO, F_ONE,
                     F_NEG_ONE, F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE, F_ONE), 1'b0);
    // flat box at the origin, signed zero exit kept
    queue_ray(mk_ray(POS_ZERO, POS_ZERO, F_ONE, POS_ZERO, POS_ZERO, F_ONE,
                     F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE, F_ONE, F_ONE), 1'b0);
    queue_ray(mk_ray(POS_ZERO, POS_ZERO, F_ONE, POS_ZERO, POS_ZERO, F_NEG_ONE,
                     F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE, F_ONE, F_ONE), 1'b1);
    // overflowing and infinite slab distances
    queue_ray(mk_ray(POS_ZERO, POS_ZERO, F_NEG_FIVE, POS_ZERO, POS_ZERO, F_TINY,
                     F_NEG_ONE, F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE, F_ONE), 1'b0);
    queue_ray(mk_ray(POS_ZERO, POS_ZERO, F_NEG_FIVE, POS_ZERO, POS_ZERO, F_INF,
                     F_NEG_ONE, F_NEG_ONE, F_NEG_ONE, F_ONE, F_ONE, F_ONE), 1'b0);
    queue_ray(mk_ray(POS_ZERO, POS_ZERO, F_NEG_INF, POS_ZERO, POS_ZERO, F_ONE,
                     F_NEG_ONE, F_NEG_ONE, F_NEG_ONE, F_ONE, F_INF, F_INF), 1'b0);
    queue_ray(mk_ray(FLT_MAX_NEG, POS_ZERO, POS_ZERO, F_TINY, POS_ZERO, POS_ZERO,
                     FLT_MAX_POS, F_NEG_ONE, F_NEG_ONE, FLT_MAX_POS, F_ONE, F_ONE), 1'b0);
    // all ones, all zeros and the largest finite value in every field
    queue_ray('1, 1'b0);
    queue_ray('0, 1'b0);
    queue_ray({12{32'h7F7F_FFFF}}, 1'b0);

    // random part: mostly aimed rays, some odd values, some raw bits
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2: queue_ray({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom},
                           i == 300 || i == 600);
        3, 4, 5, 6, 7: queue_ray(odd_ray(), i == 300 || i == 600);
        default: queue_ray(aimed_ray(), i == 300 || i == 600);
      endcase
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_rays_q.size() != 0 || start) @(posedge clk);
    while (expected_hits_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** ray_box_slab_intersect: PASSED **");
    end else begin
      $display("** ray_box_slab_intersect: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
